@@ hdl/rssg_pkg.sv @@
// Package for the running span core: sizes, stack entry layout and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package rssg_pkg;

   localparam int STACK_DEPTH = 1024;
   localparam int VALUE_BITS  = 32;
   localparam int SPAN_BITS   = 32;
   localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
   localparam int FILL_BITS   = $clog2(STACK_DEPTH + 1);
   localparam int ENTRY_BITS  = VALUE_BITS + SPAN_BITS;

   typedef struct packed {
      logic load;
      logic pop;
      logic push;
   } dp_cmd_type;

   typedef struct packed {
      logic fill_zero;
      logic last_entry;
      logic top_le;
      logic out_free;
   } dp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_COMPARE = 3'b010,
      ST_PUSH    = 3'b100
   } ctrl_state_type;

endpackage

`default_nettype wire

@@ hdl/running_span_since_greater_core.sv @@
// Running span core: one price per transaction, one span per transaction.
// One item at a time: a new price is taken only once the previous item's result is pushed,
// and a stalled result register can hold that push. Each stack entry is popped at most once.
// The pop loop is set by the RAM's registered read.
// Synchronous reset empties the stack and clears the overflow flag; contents need no clearing.
`default_nettype none

module running_span_since_greater_core
   import rssg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [VALUE_BITS-1:0] req_price,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [SPAN_BITS-1:0]  rsp_span,
   output logic                       rsp_unreliable
);

   dp_cmd_type    cmd;
   dp_status_type status;

   rssg_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   rssg_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_price     (req_price),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_span      (rsp_span),
      .rsp_unreliable(rsp_unreliable)
   );

   // A valid result always covers at least its own item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_span != '0))
      else $error("result with zero span");

   // Once a result reports overflow, every later result does too.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_unreliable) |=> (!rsp_valid || rsp_unreliable))
      else $error("overflow flag cleared");

   // A result never appears in the cycle right after an input transaction.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result too early after input transaction");

   // Pop and push are never commanded together with a load.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!cmd.pop && !cmd.push))
      else $error("conflicting datapath commands");

endmodule

`default_nettype wire

@@ hdl/rssg_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module rssg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/rssg_ctrl.sv @@
// Controller state machine of the running span core: accept, pop loop, push.
// Depends on rssg_pkg.
`default_nettype none

module rssg_ctrl
   import rssg_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.fill_zero ? ST_PUSH : ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (status.top_le) begin
               cmd.pop  = 1'b1;
               state_in = status.last_entry ? ST_PUSH : ST_COMPARE;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

@@ hdl/rssg_datapath.sv @@
// Datapath of the running span core: item registers, stack RAM, fill count,
// saturating span sum and the result register. Depends on rssg_pkg, rssg_ram.
`default_nettype none

module rssg_datapath
   import rssg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dp_cmd_type            cmd,
   output dp_status_type              status,
   input  wire logic [VALUE_BITS-1:0] req_price,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [SPAN_BITS-1:0]  rsp_span,
   output logic                       rsp_unreliable
);

   logic [VALUE_BITS-1:0] price_ff;
   logic [SPAN_BITS-1:0]  span_ff;
   logic [SPAN_BITS-1:0]  span_in;
   logic [FILL_BITS-1:0]  fill_ff;
   logic [FILL_BITS-1:0]  fill_in;
   logic                  overflow_ff;
   logic                  overflow_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [SPAN_BITS-1:0]  rsp_span_ff;
   logic                  rsp_unreliable_ff;

   logic [FILL_BITS-1:0]  fill_less1;
   logic [FILL_BITS-1:0]  fill_less2;
   logic                  full;
   logic [SPAN_BITS:0]    span_sum;
   logic                  rd_en;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [ENTRY_BITS-1:0] rd_data;
   logic [VALUE_BITS-1:0] top_value;
   logic [SPAN_BITS-1:0]  top_span;
   logic                  wr_en;

   assign fill_less1 = fill_ff - FILL_BITS'(1);
   assign fill_less2 = fill_ff - FILL_BITS'(2);
   assign full       = (fill_ff == FILL_BITS'(STACK_DEPTH));
   assign top_value  = rd_data[ENTRY_BITS-1:SPAN_BITS];
   assign top_span   = rd_data[SPAN_BITS-1:0];
   assign span_sum   = {1'b0, span_ff} + {1'b0, top_span};

   assign rd_en   = cmd.load | cmd.pop;
   assign rd_addr = cmd.load ? fill_less1[ADDR_BITS-1:0] : fill_less2[ADDR_BITS-1:0];
   assign wr_en   = cmd.push & ~full;

   rssg_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(fill_ff[ADDR_BITS-1:0]),
      .wr_data({price_ff, span_ff}),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      span_in      = span_ff;
      fill_in      = fill_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (cmd.load) begin
         span_in = SPAN_BITS'(1);
      end
      if (cmd.pop) begin
         span_in = span_sum[SPAN_BITS] ? {SPAN_BITS{1'b1}} : span_sum[SPAN_BITS-1:0];
         fill_in = fill_less1;
      end
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            fill_in = fill_ff + FILL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= span_in;
      if (cmd.load) begin
         price_ff <= req_price;
      end
      if (cmd.push) begin
         rsp_span_ff       <= span_ff;
         rsp_unreliable_ff <= overflow_ff | full;
      end
   end

   assign status.fill_zero  = (fill_ff == '0);
   assign status.last_entry = (fill_ff == FILL_BITS'(1));
   assign status.top_le     = (top_value <= price_ff);
   assign status.out_free   = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_span       = rsp_span_ff;
   assign rsp_unreliable = rsp_unreliable_ff;

endmodule

`default_nettype wire
